>>> sv/prq_pkg.sv
// Shared types, request and status codes, and default sizes for the ready-queue scheduler.
package prq_pkg;

  localparam int THREADS_DEF = 8;
  localparam int LEVELS_DEF  = 16;

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_GET   = 2'd1;
  localparam logic [1:0] REQ_SCHED = 2'd2;
  localparam logic [1:0] REQ_CHPRI = 2'd3;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_NOP   = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // Commands from the controller to the datapath, at most one active per cycle.
  typedef struct packed {
    logic load_req;
    logic rd_lvl;
    logic rd_que;
    logic rd_hlv;
    logic exec;
  } prq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_sched;
  } prq_stat_t;

endpackage

>>> sv/prq_datapath.sv
// Datapath of the ready-queue scheduler: request registers, queue storage and result register.
module prq_datapath #(
  parameter int THREADS = prq_pkg::THREADS_DEF,
  parameter int LEVELS  = prq_pkg::LEVELS_DEF,
  localparam int TIDW   = $clog2(THREADS),
  localparam int PRIW   = $clog2(LEVELS)
) (
  input  logic                clk,
  input  logic                rst,
  input  prq_pkg::prq_cmd_t   cmd,
  output prq_pkg::prq_stat_t  stat,
  input  logic [1:0]          req_type,
  input  logic [TIDW-1:0]     thread_id,
  input  logic [PRIW-1:0]     new_priority,
  input  logic                keep_priority,
  output logic [1:0]          status,
  output logic [TIDW-1:0]     thread_out,
  output logic [PRIW-1:0]     old_priority
);

  localparam logic [TIDW:0] THREADS_W = (TIDW+1)'(THREADS);
  localparam logic [PRIW:0] LEVELS_W  = (PRIW+1)'(LEVELS);

  // Request registers.
  logic [1:0]      req_q;
  logic [TIDW-1:0] t_q;
  logic [PRIW-1:0] np_q;
  logic            keep_q;

  // Queue storage.
  logic [PRIW-1:0] thread_level   [THREADS];
  logic [TIDW-1:0] thread_link    [THREADS];
  logic [TIDW-1:0] level_head     [LEVELS];
  logic [TIDW-1:0] level_tail     [LEVELS];
  logic            thread_ready   [THREADS];
  logic            level_nonempty [LEVELS];

  // Read data and intermediate registers.
  logic [PRIW-1:0] lvl_rd;
  logic [PRIW-1:0] lvl_q;
  logic [PRIW-1:0] lvl_use_q;
  logic [PRIW-1:0] enc_q;
  logic            any_q;
  logic [TIDW-1:0] head_q;
  logic [TIDW-1:0] tail_q;
  logic [TIDW-1:0] link_q;

  logic [PRIW-1:0] enc;
  logic            any;
  logic            t_ok;
  logic            rdy_t;
  logic            is_sched;
  logic [PRIW-1:0] sat_np;
  logic [PRIW-1:0] lvl_sel;
  logic [TIDW-1:0] lvl_addr;
  logic            nonempty_l;
  logic            do_enq;
  logic            do_get;
  logic            get_tail;
  logic            set_level;

  assign is_sched  = (req_q == prq_pkg::REQ_SCHED);
  assign stat.is_sched = is_sched;
  assign t_ok      = ({1'b0, t_q} < THREADS_W);
  assign rdy_t     = t_ok ? thread_ready[t_q] : 1'b0;
  assign sat_np    = ({1'b0, np_q} >= LEVELS_W) ? PRIW'(LEVELS - 1) : np_q;
  assign set_level = (req_q == prq_pkg::REQ_CHPRI) && !rdy_t && !keep_q;
  assign lvl_sel   = is_sched ? enc_q : (set_level ? sat_np : lvl_rd);
  assign lvl_addr  = cmd.rd_hlv ? head_q : t_q;
  assign nonempty_l = level_nonempty[lvl_use_q];
  assign do_enq    = t_ok && !rdy_t &&
                     ((req_q == prq_pkg::REQ_PUT) || (req_q == prq_pkg::REQ_CHPRI));
  assign do_get    = t_ok && rdy_t && (req_q == prq_pkg::REQ_GET);
  // The popped thread was the only one left, or the level was already empty.
  assign get_tail  = !(nonempty_l && (tail_q != t_q));

  // Lowest-numbered non-empty level.
  always_comb begin
    enc = '0;
    any = 1'b0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (level_nonempty[i]) begin
        enc = PRIW'(i);
        any = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q  <= req_type;
      t_q    <= thread_id;
      np_q   <= new_priority;
      keep_q <= keep_priority;
    end
    if (cmd.rd_lvl) begin
      enc_q <= enc;
      any_q <= any;
    end
    if (cmd.rd_lvl || cmd.rd_hlv) begin
      lvl_rd <= thread_level[lvl_addr];
    end
    if (cmd.rd_que) begin
      lvl_q     <= lvl_rd;
      lvl_use_q <= lvl_sel;
      head_q    <= level_head[lvl_sel];
      tail_q    <= level_tail[lvl_sel];
      link_q    <= thread_link[t_q];
    end
  end

  // Memory writes, all in the execute cycle.
  always_ff @(posedge clk) begin
    if (cmd.exec && do_enq && set_level) begin
      thread_level[t_q] <= lvl_use_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && do_enq && nonempty_l) begin
      thread_link[tail_q] <= t_q;
    end else if (cmd.exec && do_get) begin
      thread_link[t_q] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && do_enq && !nonempty_l) begin
      level_head[lvl_use_q] <= t_q;
    end else if (cmd.exec && do_get && !get_tail) begin
      level_head[lvl_use_q] <= link_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && do_enq) begin
      level_tail[lvl_use_q] <= t_q;
    end
  end

  // Flags with a known reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < THREADS; i++) begin
        thread_ready[i] <= 1'b0;
      end
      for (int i = 0; i < LEVELS; i++) begin
        level_nonempty[i] <= 1'b0;
      end
    end else if (cmd.exec) begin
      if (do_enq) begin
        thread_ready[t_q]         <= 1'b1;
        level_nonempty[lvl_use_q] <= 1'b1;
      end else if (do_get) begin
        thread_ready[t_q] <= 1'b0;
        if (get_tail) begin
          level_nonempty[lvl_use_q] <= 1'b0;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (is_sched) begin
        if (any_q) begin
          status       <= prq_pkg::STAT_DONE;
          thread_out   <= head_q;
          old_priority <= lvl_rd;
        end else begin
          status       <= prq_pkg::STAT_EMPTY;
          thread_out   <= '0;
          old_priority <= '0;
        end
      end else begin
        thread_out <= t_q;
        if (!t_ok) begin
          status       <= prq_pkg::STAT_NOP;
          old_priority <= '0;
        end else begin
          status       <= (do_enq || do_get) ? prq_pkg::STAT_DONE : prq_pkg::STAT_NOP;
          old_priority <= lvl_q;
        end
      end
    end
  end

endmodule

>>> sv/prq_ctrl.sv
// Controller of the ready-queue scheduler: request sequencing and result handshake.
module prq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  input  prq_pkg::prq_stat_t  stat,
  output prq_pkg::prq_cmd_t   cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LVL  = 3'd1;
  localparam logic [2:0] ST_QUE  = 3'd2;
  localparam logic [2:0] ST_HLV  = 3'd3;
  localparam logic [2:0] ST_EXE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        cmd.load_req = req_valid;
        if (req_valid) state_next = ST_LVL;
      end
      ST_LVL: begin
        cmd.rd_lvl = 1'b1;
        state_next = ST_QUE;
      end
      ST_QUE: begin
        cmd.rd_que = 1'b1;
        state_next = stat.is_sched ? ST_HLV : ST_EXE;
      end
      ST_HLV: begin
        cmd.rd_hlv = 1'b1;
        state_next = ST_EXE;
      end
      ST_EXE: begin
        cmd.exec = !rsp_valid || !rsp_stall;
        if (cmd.exec) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == ST_LVL))
    else $error("accepted item did not start the read sequence");

  a_exec_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXE && rsp_valid && rsp_stall) |=> (state == ST_EXE && rsp_valid))
    else $error("execute did not wait for a pending result");

  a_cmd_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_req, cmd.rd_lvl, cmd.rd_que, cmd.rd_hlv, cmd.exec}))
    else $error("more than one datapath command in a cycle");

  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> (rsp_valid && state == ST_IDLE))
    else $error("execute did not present a result and return to idle");
`endif

endmodule

>>> sv/priority_ready_queue_scheduler.sv
// Top level of the fixed-priority FIFO ready-queue scheduler.
// This block keeps one FIFO ready queue per priority level for a fixed-priority
// kernel, with a level, a ready flag and a next link per thread and a head, a
// tail and a non-empty flag per level. Each accepted request item gives exactly
// one result item. A request is taken while the block is idle and then runs
// through register-file reads with registered read data: the thread's level,
// then the chosen level's head, tail and the thread's link, and for schedule a
// second read of the head thread's level, followed by an execute cycle that
// updates the queues and loads the result register. Schedule uses the read
// port of the thread level store twice, so only schedule has the head level
// read. The result register holds a finished item while the next request is
// already accepted and read; only the execute cycle waits for the previous
// result to be taken. Level 0 is the most urgent.
// Ready and non-empty flags clear at reset; levels, links, heads and tails are
// valid only once written, so a put of a thread whose level was never set is
// not meaningful.
module priority_ready_queue_scheduler #(
  parameter int THREADS = prq_pkg::THREADS_DEF,
  parameter int LEVELS  = prq_pkg::LEVELS_DEF,
  localparam int TIDW   = $clog2(THREADS),
  localparam int PRIW   = $clog2(LEVELS)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  logic [1:0]      req_type,
  input  logic [TIDW-1:0] thread_id,
  input  logic [PRIW-1:0] new_priority,
  input  logic            keep_priority,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output logic [1:0]      status,
  output logic [TIDW-1:0] thread_out,
  output logic [PRIW-1:0] old_priority
);

  prq_pkg::prq_cmd_t  cmd;
  prq_pkg::prq_stat_t stat;

  // Sequencing and handshakes.
  prq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Queue storage and result computation.
  prq_datapath #(
    .THREADS (THREADS),
    .LEVELS  (LEVELS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .req_type      (req_type),
    .thread_id     (thread_id),
    .new_priority  (new_priority),
    .keep_priority (keep_priority),
    .status        (status),
    .thread_out    (thread_out),
    .old_priority  (old_priority)
  );

endmodule
